[rtl/core/work_stealing_task_queues_defines.svh]
// work_stealing_task_queues_defines.svh: assertion macros for the task queue checker.
// Depends on nothing; the user supplies clk_i and rst_ni in scope.
`ifndef WORK_STEALING_TASK_QUEUES_DEFINES_SVH
`define WORK_STEALING_TASK_QUEUES_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WSTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/wstq_pkg.sv]
// wstq_pkg.sv: shared constants, codes and helpers of the task queue block.
// Depends on nothing; used by all RTL modules of the block.
`timescale 1ns / 1ps
`default_nettype none

package wstq_pkg;

  // Parameter defaults.
  localparam int unsigned NUM_EXECUTORS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH_DEF   = 64;
  localparam int unsigned TASK_BITS_DEF     = 16;

  // Fixed field widths.
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned ID_W       = 4;
  localparam int unsigned HANDLE_W   = 16;
  localparam int unsigned SRC_W      = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned ACTIVE_W   = 5;
  localparam int unsigned SEED_W     = 16;
  localparam int unsigned LFSR_W     = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LFSR_W-1:0]   LFSR_TAPS    = 16'hB400;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;
  localparam logic [SEED_W-1:0]   SEED_RESET   = 16'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE = 1'b0,
    CFG_SEED   = 1'b1
  } cfg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 1'b0,
    CMD_GET = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BAD_ID = 2'd3
  } status_e;

  // One right shift of the Galois LFSR.
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] s;
    s = v >> 1;
    if (v[0]) begin
      s = s ^ LFSR_TAPS;
    end
    return s;
  endfunction

  // A zero seed would lock the LFSR, so it loads as one.
  function automatic logic [LFSR_W-1:0] seed_load(input logic [SEED_W-1:0] seed);
    logic [LFSR_W-1:0] v;
    v = LFSR_W'(seed);
    if (v == '0) begin
      v = LFSR_W'(1);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wstq_mod.sv]
// wstq_mod.sv: bit-serial remainder unit, one dividend bit per cycle.
// Depends on wstq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wstq_mod #(
  parameter int unsigned DIVIDEND_W = wstq_pkg::LFSR_W,
  parameter int unsigned DIVISOR_W  = 5
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  remainder_o
);
  import wstq_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [STEP_W-1:0]     step_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVISOR_W-1:0]  dsr_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  rem_d;
  logic [DIVISOR_W:0]    trial;

  // Shift the next dividend bit into the partial remainder and subtract if it fits.
  always_comb begin
    trial = {rem_q, dvd_q[DIVIDEND_W-1]};
    if (trial >= {1'b0, dsr_q}) begin
      rem_d = DIVISOR_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = DIVISOR_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

[rtl/core/work_stealing_task_queues.sv]
// work_stealing_task_queues.sv: top level of the work-stealing task queue block.
// Depends on wstq_pkg and wstq_mod.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps one task deque per executor. Each deque is a ring of QUEUE_DEPTH
// handles in a single synchronous task memory, with its head index and fill count in
// flip-flops. An add request appends a handle at the back of the named executor's deque;
// a get request pops the front of the asker's own deque, or, if that deque is empty,
// advances a 16-bit Galois LFSR, takes its value modulo the number of active executors
// as a start offset and steals the back entry of the first non-empty deque found by a
// wrapping scan from there. Every request yields exactly one result, with a status of
// ok, queue full, nothing to steal or bad executor id. The block works on one request
// at a time: a bad id or a full queue goes from decode straight to the done state, an
// add passes decode, access and done, and a pop from the own deque adds a read state
// for the registered read of the task memory. A steal spends most of its time in the
// bit-serial remainder unit that reduces the 16-bit LFSR value one bit per cycle;
// the scan itself is a registered mask followed by a priority pick. A new request is
// taken as soon as the previous result sits in the output register, even if the
// receiver is still stalling it. Configuration writes take effect at once and are meant
// for idle periods only; writing the seed reloads the LFSR. The task memory needs no
// clearing after reset, since the fill counts guard every read.
module work_stealing_task_queues #(
  parameter int unsigned NUM_EXECUTORS = wstq_pkg::NUM_EXECUTORS_DEF,
  parameter int unsigned QUEUE_DEPTH   = wstq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned TASK_BITS     = wstq_pkg::TASK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port.
  input  logic                            cfg_we_i,
  input  logic [wstq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wstq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Request channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wstq_pkg::CMD_W-1:0]      cmd_i,
  input  logic [wstq_pkg::ID_W-1:0]       executor_id_i,
  input  logic [wstq_pkg::HANDLE_W-1:0]   task_handle_i,
  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            task_valid_o,
  output logic [wstq_pkg::HANDLE_W-1:0]   task_out_o,
  output logic [wstq_pkg::SRC_W-1:0]      source_queue_o,
  output logic                            was_stolen_o,
  output logic [wstq_pkg::STATUS_W-1:0]   status_o
);
  import wstq_pkg::*;

  // Stored handle width: the handle port never carries more than HANDLE_W bits.
  localparam int unsigned SW        = (TASK_BITS < HANDLE_W) ? TASK_BITS : HANDLE_W;
  localparam int unsigned QW        = $clog2(NUM_EXECUTORS);
  localparam int unsigned NW        = $clog2(NUM_EXECUTORS + 1);
  localparam int unsigned PW        = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW        = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUMW      = CW + 1;
  localparam int unsigned MEM_DEPTH = NUM_EXECUTORS * QUEUE_DEPTH;
  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned CMPW      = (NW > ACTIVE_W) ? NW : ACTIVE_W;
  localparam int unsigned IDCW      = (NW > ID_W) ? NW : ID_W;
  localparam int unsigned QIW       = (QW > ID_W) ? QW : ID_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_ACCESS = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]            state_q;
  logic [2:0]            state_d;

  // Configuration and victim selection.
  logic [ACTIVE_W-1:0]   active_q;
  logic [LFSR_W-1:0]     lfsr_q;
  logic [LFSR_W-1:0]     lfsr_next;
  logic [CMPW-1:0]       act_ext;
  logic [CMPW-1:0]       n_cmp;
  logic [NW-1:0]         n_active;

  // Request held while it is worked on.
  logic [CMD_W-1:0]      cmd_q;
  logic [ID_W-1:0]       id_q;
  logic [SW-1:0]         handle_q;
  logic [QW-1:0]         cur_q;
  logic                  steal_q;
  logic [NW-1:0]         offset_q;

  // Per-queue head and count registers.
  logic [PW-1:0]         head_q [NUM_EXECUTORS];
  logic [CW-1:0]         cnt_q  [NUM_EXECUTORS];
  logic [PW-1:0]         head_cur;
  logic [CW-1:0]         cnt_cur;
  logic [PW-1:0]         head_inc;

  // Victim scan.
  logic [NUM_EXECUTORS-1:0] nz_all_d;
  logic [NUM_EXECUTORS-1:0] nz_hi_d;
  logic [NUM_EXECUTORS-1:0] nz_all_q;
  logic [NUM_EXECUTORS-1:0] nz_hi_q;
  logic [NUM_EXECUTORS-1:0] sel_vec;
  logic                     pick_found;
  logic [QW-1:0]            pick_idx;

  // Task memory access.
  logic [SW-1:0]         mem [MEM_DEPTH];
  logic [SW-1:0]         mem_rdata_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [SUMW-1:0]       pos_base;
  logic [SUMW-1:0]       pos_wrap;
  logic [PW-1:0]         pos;
  logic [AW-1:0]         addr;

  // Result under construction.
  logic                  res_valid_q;
  logic                  res_stolen_q;
  logic [STATUS_W-1:0]   res_status_q;

  // Output register.
  logic                  out_valid_q;
  logic                  task_valid_q;
  logic [HANDLE_W-1:0]   task_out_q;
  logic [SRC_W-1:0]      source_q;
  logic                  stolen_q;
  logic [STATUS_W-1:0]   status_q;

  logic                  id_bad;
  logic                  own_full;
  logic                  out_free;
  logic                  in_accept;
  logic                  mod_start;
  logic                  mod_done;
  logic [NW-1:0]         mod_rem;

  // Active executor count, clamped into one to NUM_EXECUTORS.
  always_comb begin
    act_ext = CMPW'(active_q);
    if (act_ext == '0) begin
      n_cmp = CMPW'(1);
    end else if (act_ext > CMPW'(NUM_EXECUTORS)) begin
      n_cmp = CMPW'(NUM_EXECUTORS);
    end else begin
      n_cmp = act_ext;
    end
    n_active = NW'(n_cmp);
  end

  assign lfsr_next = lfsr_step(lfsr_q);
  assign id_bad    = IDCW'(id_q) >= IDCW'(n_active);
  assign head_cur  = head_q[cur_q];
  assign cnt_cur   = cnt_q[cur_q];
  assign own_full  = cnt_cur >= CW'(QUEUE_DEPTH);
  assign head_inc  = (head_cur == PW'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = state_q != S_IDLE;
  assign in_accept = in_valid_i && !in_stall_o;
  assign mod_start = (state_q == S_DECODE) && !id_bad && (cmd_q == CMD_GET) &&
                     (cnt_cur == '0);

  // Ring position: back slot for an add, last slot for a steal, head for a pop.
  always_comb begin
    if (cmd_q == CMD_ADD) begin
      pos_base = SUMW'(head_cur) + SUMW'(cnt_cur);
    end else if (steal_q) begin
      pos_base = SUMW'(head_cur) + SUMW'(cnt_cur) - SUMW'(1);
    end else begin
      pos_base = SUMW'(head_cur);
    end
    if (pos_base >= SUMW'(QUEUE_DEPTH)) begin
      pos_wrap = pos_base - SUMW'(QUEUE_DEPTH);
    end else begin
      pos_wrap = pos_base;
    end
    pos  = PW'(pos_wrap);
    addr = AW'(cur_q) * AW'(QUEUE_DEPTH) + AW'(pos);
  end

  assign mem_we = (state_q == S_ACCESS) && (cmd_q == CMD_ADD);
  assign mem_re = (state_q == S_ACCESS) && (cmd_q == CMD_GET);

  // Non-empty masks for the wrapping scan: all active queues, and those from the offset up.
  always_comb begin
    for (int q = 0; q < NUM_EXECUTORS; q++) begin
      nz_all_d[q] = (cnt_q[q] != '0) && (q < int'(n_active));
      nz_hi_d[q]  = nz_all_d[q] && (q >= int'(offset_q));
    end
  end

  // The first non-empty queue at or after the offset wins, else the first from zero.
  always_comb begin
    sel_vec    = (|nz_hi_q) ? nz_hi_q : nz_all_q;
    pick_found = |sel_vec;
    pick_idx   = '0;
    for (int q = NUM_EXECUTORS - 1; q >= 0; q--) begin
      if (sel_vec[q]) begin
        pick_idx = QW'(q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (id_bad) begin
          state_d = S_DONE;
        end else if (cmd_q == CMD_ADD) begin
          state_d = own_full ? S_DONE : S_ACCESS;
        end else if (cnt_cur != '0) begin
          state_d = S_ACCESS;
        end else begin
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        state_d = S_PICK;
      end
      S_PICK: begin
        state_d = pick_found ? S_ACCESS : S_DONE;
      end
      S_ACCESS: begin
        state_d = (cmd_q == CMD_ADD) ? S_DONE : S_READ;
      end
      S_READ: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  wstq_mod #(
    .DIVIDEND_W (LFSR_W),
    .DIVISOR_W  (NW)
  ) u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (mod_start),
    .dividend_i  (lfsr_next),
    .divisor_i   (n_active),
    .done_o      (mod_done),
    .remainder_o (mod_rem)
  );

  // Control state, configuration and queue bookkeeping.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= ACTIVE_RESET;
      lfsr_q      <= seed_load(SEED_RESET);
      out_valid_q <= 1'b0;
      for (int q = 0; q < NUM_EXECUTORS; q++) begin
        head_q[q] <= '0;
        cnt_q[q]  <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_ACTIVE: active_q <= cfg_data_i[ACTIVE_W-1:0];
          CFG_SEED:   lfsr_q   <= seed_load(cfg_data_i[SEED_W-1:0]);
        endcase
      end else if (mod_start) begin
        lfsr_q <= lfsr_next;
      end

      if (state_q == S_ACCESS) begin
        if (cmd_q == CMD_ADD) begin
          cnt_q[cur_q] <= cnt_cur + CW'(1);
        end else begin
          cnt_q[cur_q] <= cnt_cur - CW'(1);
          if (!steal_q) begin
            head_q[cur_q] <= head_inc;
          end
        end
      end

      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_i;
      id_q     <= executor_id_i;
      handle_q <= task_handle_i[SW-1:0];
      cur_q    <= QW'(executor_id_i);
      steal_q  <= 1'b0;
    end

    if (state_q == S_DECODE) begin
      res_valid_q  <= 1'b0;
      res_stolen_q <= 1'b0;
      if (id_bad) begin
        res_status_q <= ST_BAD_ID;
      end else if (cmd_q == CMD_ADD && own_full) begin
        res_status_q <= ST_FULL;
      end else begin
        res_status_q <= ST_OK;
      end
      if (mod_start) begin
        steal_q <= 1'b1;
      end
    end

    if (state_q == S_MOD && mod_done) begin
      offset_q <= mod_rem;
    end

    if (state_q == S_SCAN) begin
      nz_all_q <= nz_all_d;
      nz_hi_q  <= nz_hi_d;
    end

    if (state_q == S_PICK) begin
      cur_q        <= pick_idx;
      res_status_q <= pick_found ? ST_OK : ST_EMPTY;
    end

    if (state_q == S_ACCESS && cmd_q == CMD_GET) begin
      res_valid_q  <= 1'b1;
      res_stolen_q <= steal_q && (QIW'(cur_q) != QIW'(id_q));
    end

    if (state_q == S_DONE && out_free) begin
      task_valid_q <= res_valid_q;
      task_out_q   <= res_valid_q ? HANDLE_W'(mem_rdata_q) : '0;
      source_q     <= res_valid_q ? SRC_W'(cur_q) : '0;
      stolen_q     <= res_stolen_q;
      status_q     <= res_status_q;
    end
  end

  // Task memory: one write or one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= handle_q;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign task_valid_o   = task_valid_q;
  assign task_out_o     = task_out_q;
  assign source_queue_o = source_q;
  assign was_stolen_o   = stolen_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

[rtl/core/wstq_checker.sv]
// wstq_checker.sv: port-level checks of the task queue result channel, and their binding.
// Depends on wstq_pkg and work_stealing_task_queues_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "work_stealing_task_queues_defines.svh"

module wstq_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            task_valid_o,
  input logic [wstq_pkg::HANDLE_W-1:0]   task_out_o,
  input logic [wstq_pkg::SRC_W-1:0]      source_queue_o,
  input logic                            was_stolen_o,
  input logic [wstq_pkg::STATUS_W-1:0]   status_o
);
  import wstq_pkg::*;

  // A handed out task always comes with an ok status.
  `WSTQ_ASSERT_NOW(a_task_ok, out_valid_o && task_valid_o, status_o == ST_OK, "task with bad status")

  // Only a handed out task can be marked as stolen.
  `WSTQ_ASSERT_NOW(a_stolen_task, out_valid_o && was_stolen_o, task_valid_o, "stolen without task")

  // Without a task the handle and source fields read as zero.
  `WSTQ_ASSERT_NOW(a_idle_zero, out_valid_o && !task_valid_o, (task_out_o == '0) && (source_queue_o == '0), "fields not cleared")

  // A stalled result holds until it is taken.
  `WSTQ_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(task_out_o) && $stable(status_o), "stalled result changed")

endmodule

bind work_stealing_task_queues wstq_checker u_wstq_checker (.*);

`default_nettype wire
